>>> sv/hybrid_branch_predictor_macros.svh
// ----------------------------------------------------------------------------
// Hybrid branch predictor assertion macros
// Same-cycle implication and next-cycle checks, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HYBRID_BRANCH_PREDICTOR_MACROS_SVH
`define HYBRID_BRANCH_PREDICTOR_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define HBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbp check failed");

// next-cycle implication
`define HBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbp check failed");

`else

`define HBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/hbp_pkg.sv
// ----------------------------------------------------------------------------
// Hybrid branch predictor package
// Table sizes, register codes, payload types and counter helpers.
// ----------------------------------------------------------------------------
package hbp_pkg;

    // table geometry
    localparam int MAX_BIMODAL_BITS = 12;
    localparam int MAX_GSHARE_BITS  = 12;
    localparam int MAX_CHOOSER_BITS = 12;
    localparam int COUNT_WIDTH      = 32;

    localparam int CLR_BITS_BG = (MAX_BIMODAL_BITS > MAX_GSHARE_BITS) ?
                                 MAX_BIMODAL_BITS : MAX_GSHARE_BITS;
    localparam int CLR_BITS    = (CLR_BITS_BG > MAX_CHOOSER_BITS) ?
                                 CLR_BITS_BG : MAX_CHOOSER_BITS;

    // clamped bit-count width (holds up to 31)
    localparam int BITS_W = 5;

    localparam logic [BITS_W-1:0] BIM_MAX = BITS_W'(MAX_BIMODAL_BITS);
    localparam logic [BITS_W-1:0] GSH_MAX = BITS_W'(MAX_GSHARE_BITS);
    localparam logic [BITS_W-1:0] CHO_MAX = BITS_W'(MAX_CHOOSER_BITS);

    // 2-bit saturating counters
    localparam int CTR_W = 2;
    localparam logic [CTR_W-1:0] CTR_BIM_INIT = 2'd2;
    localparam logic [CTR_W-1:0] CTR_GSH_INIT = 2'd2;
    localparam logic [CTR_W-1:0] CTR_CHO_INIT = 2'd1;
    localparam logic [CTR_W-1:0] CTR_MAX      = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN      = 2'd0;

    // mode codes; any other code runs as hybrid
    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_HYBRID  = 2'd2;

    // config register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIM_BITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GSH_BITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIST_BITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHO_BITS  = 3'd4;

    // request and response payloads
    typedef struct packed {
        logic [31:0] branch_address;
        logic        taken;
    } t_branch_req;

    typedef struct packed {
        logic        predicted_taken;
        logic        mispredicted;
        logic [31:0] mispredict_total;
    } t_branch_rsp;

    // configuration registers
    typedef struct packed {
        logic [1:0]           mode;
        logic [CFG_DAT_W-1:0] bim_bits;
        logic [CFG_DAT_W-1:0] gsh_bits;
        logic [CFG_DAT_W-1:0] hist_bits;
        logic [CFG_DAT_W-1:0] cho_bits;
    } t_cfg;

    // table indexes of one branch
    typedef struct packed {
        logic [MAX_BIMODAL_BITS-1:0] bim;
        logic [MAX_GSHARE_BITS-1:0]  gsh;
        logic [MAX_CHOOSER_BITS-1:0] cho;
    } t_index;

    // table updates of one branch
    typedef struct packed {
        logic             bim_we;
        logic [CTR_W-1:0] bim_data;
        logic             gsh_we;
        logic [CTR_W-1:0] gsh_data;
        logic             cho_we;
        logic [CTR_W-1:0] cho_data;
    } t_wr;

    // saturating counter step
    function automatic logic [CTR_W-1:0] ctr_train(logic [CTR_W-1:0] ctr, logic up);
        logic [CTR_W-1:0] res;
        if (up) begin
            res = (ctr == CTR_MAX) ? CTR_MAX : ctr + CTR_W'(1);
        end else begin
            res = (ctr == CTR_MIN) ? CTR_MIN : ctr - CTR_W'(1);
        end
        return res;
    endfunction

    // limit a bit count to 1..hi
    function automatic logic [BITS_W-1:0] clamp_bits(logic [BITS_W-1:0] v,
                                                     logic [BITS_W-1:0] hi);
        logic [BITS_W-1:0] res;
        if (v == '0) begin
            res = BITS_W'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

>>> sv/hbp_ram.sv
// ----------------------------------------------------------------------------
// Hybrid branch predictor table RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hbp_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 2
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/hbp_index.sv
// ----------------------------------------------------------------------------
// Hybrid branch predictor index unit
// Table indexes and next global history for an incoming branch.
// ----------------------------------------------------------------------------
module hbp_index
    import hbp_pkg::*;
(
    input  t_branch_req                 i_req,
    input  t_cfg                        i_cfg,
    input  logic [MAX_GSHARE_BITS-1:0]  i_hist,
    output t_index                      o_idx,
    output logic [MAX_GSHARE_BITS-1:0]  o_hist_next,
    output logic                        o_hist_shift
);

    logic [29:0]                 pc;
    logic [BITS_W-1:0]           b_bits;
    logic [BITS_W-1:0]           m_bits;
    logic [BITS_W-1:0]           n_bits;
    logic [BITS_W-1:0]           c_bits;
    logic [MAX_BIMODAL_BITS-1:0] bim_mask;
    logic [MAX_GSHARE_BITS-1:0]  gsh_mask;
    logic [MAX_GSHARE_BITS-1:0]  hist_mask;
    logic [MAX_CHOOSER_BITS-1:0] cho_mask;
    logic [MAX_GSHARE_BITS-1:0]  hist_use;

    assign pc = i_req.branch_address[31:2];

    // effective bit counts
    always_comb begin
        b_bits = clamp_bits({1'b0, i_cfg.bim_bits}, BIM_MAX);
        m_bits = clamp_bits({1'b0, i_cfg.gsh_bits}, GSH_MAX);
        n_bits = clamp_bits({1'b0, i_cfg.hist_bits}, m_bits);
        c_bits = clamp_bits({1'b0, i_cfg.cho_bits}, CHO_MAX);
    end

    // low-bit masks
    always_comb begin
        bim_mask  = ~({MAX_BIMODAL_BITS{1'b1}} << b_bits);
        gsh_mask  = ~({MAX_GSHARE_BITS{1'b1}} << m_bits);
        hist_mask = ~({MAX_GSHARE_BITS{1'b1}} << n_bits);
        cho_mask  = ~({MAX_CHOOSER_BITS{1'b1}} << c_bits);
    end

    // history aligned to the top of the gshare index
    assign hist_use = i_hist & hist_mask;

    always_comb begin
        o_idx.bim = pc[MAX_BIMODAL_BITS-1:0] & bim_mask;
        o_idx.gsh = (pc[MAX_GSHARE_BITS-1:0] ^ (hist_use << (m_bits - n_bits))) & gsh_mask;
        o_idx.cho = pc[MAX_CHOOSER_BITS-1:0] & cho_mask;
    end

    // outcome enters at the top history bit
    always_comb begin
        o_hist_next  = ((hist_use >> 1)
                       | (MAX_GSHARE_BITS'(i_req.taken) << (n_bits - BITS_W'(1))))
                       & hist_mask;
        o_hist_shift = (i_cfg.mode != MODE_BIMODAL);
    end

endmodule

>>> sv/hbp_train.sv
// ----------------------------------------------------------------------------
// Hybrid branch predictor training unit
// Prediction, chooser decision and counter updates for one branch.
// ----------------------------------------------------------------------------
module hbp_train
    import hbp_pkg::*;
(
    input  logic [1:0]       i_mode,
    input  logic             i_taken,
    input  logic [CTR_W-1:0] i_bim_ctr,
    input  logic [CTR_W-1:0] i_gsh_ctr,
    input  logic [CTR_W-1:0] i_cho_ctr,
    output logic             o_pred,
    output t_wr              o_wr
);

    logic pred_b;
    logic pred_g;
    logic use_g;
    logic hybrid;
    logic ok_b;
    logic ok_g;

    assign pred_b = i_bim_ctr[1];
    assign pred_g = i_gsh_ctr[1];
    assign ok_b   = (pred_b == i_taken);
    assign ok_g   = (pred_g == i_taken);

    // pick the predictor that is used and trained
    always_comb begin
        case (i_mode)
            MODE_BIMODAL: begin
                hybrid = 1'b0;
                use_g  = 1'b0;
            end
            MODE_GSHARE: begin
                hybrid = 1'b0;
                use_g  = 1'b1;
            end
            default: begin
                hybrid = 1'b1;
                use_g  = i_cho_ctr[1];
            end
        endcase
    end

    assign o_pred = use_g ? pred_g : pred_b;

    // table updates
    always_comb begin
        o_wr.bim_we   = !use_g;
        o_wr.bim_data = ctr_train(i_bim_ctr, i_taken);
        o_wr.gsh_we   = use_g;
        o_wr.gsh_data = ctr_train(i_gsh_ctr, i_taken);
        // chooser leans toward whichever predictor alone was right
        o_wr.cho_we   = hybrid && (ok_g != ok_b);
        o_wr.cho_data = ctr_train(i_cho_ctr, ok_g);
    end

endmodule

>>> sv/hybrid_branch_predictor.sv
// ----------------------------------------------------------------------------
// Hybrid branch predictor
// Bimodal, gshare or tournament prediction with training per resolved branch.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  i_in      in         i_in_valid / o_in_stall    t_branch_req
//  o_out     out        o_out_valid / i_out_stall  t_branch_rsp
//  i_cfg     in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One branch per cycle unless stalled; each response passes the training
//  stage and then the output register. Table reads happen at accept; training
//  writes when that stage advances, with forwarding into the next branch's read data.
//  After reset a clearing pass over 2**CLR_BITS (4096) rows loads the tables;
//  requests are stalled during it, config writes are always taken.
//  An output stall holds the training stage, which then stalls the input.
// ----------------------------------------------------------------------------
`include "hybrid_branch_predictor_macros.svh"

module hybrid_branch_predictor
    import hbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_branch_req          i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_branch_rsp          o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // control registers
    t_cfg                        r_cfg;
    logic                        r_clearing;
    logic [CLR_BITS-1:0]         r_clr_idx;
    logic [MAX_GSHARE_BITS-1:0]  r_hist;
    logic [COUNT_WIDTH-1:0]      r_cnt;
    logic                        r_s1_v;
    logic                        r_out_v;

    // stage payload
    logic                        r_s1_taken;
    t_index                      r_s1_idx;
    logic                        r_fwd_bim;
    logic                        r_fwd_gsh;
    logic                        r_fwd_cho;
    logic [CTR_W-1:0]            r_fwd_bim_val;
    logic [CTR_W-1:0]            r_fwd_gsh_val;
    logic [CTR_W-1:0]            r_fwd_cho_val;
    t_branch_rsp                 r_out;

    logic                        in_acc;
    logic                        adv;
    t_index                      idx;
    logic [MAX_GSHARE_BITS-1:0]  hist_next;
    logic                        hist_shift;
    logic [CTR_W-1:0]            bim_rd;
    logic [CTR_W-1:0]            gsh_rd;
    logic [CTR_W-1:0]            cho_rd;
    logic [CTR_W-1:0]            bim_ctr;
    logic [CTR_W-1:0]            gsh_ctr;
    logic [CTR_W-1:0]            cho_ctr;
    logic                        pred;
    logic                        mis;
    t_wr                         wr;
    logic [COUNT_WIDTH-1:0]      n_cnt;
    t_branch_rsp                 n_out;

    logic                        bim_we;
    logic                        gsh_we;
    logic                        cho_we;
    logic [MAX_BIMODAL_BITS-1:0] bim_waddr;
    logic [MAX_GSHARE_BITS-1:0]  gsh_waddr;
    logic [MAX_CHOOSER_BITS-1:0] cho_waddr;
    logic [CTR_W-1:0]            bim_wdata;
    logic [CTR_W-1:0]            gsh_wdata;
    logic [CTR_W-1:0]            cho_wdata;

    // handshake
    assign adv         = r_s1_v && (!r_out_v || !i_out_stall);
    assign o_in_stall  = r_clearing || (r_s1_v && !adv);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // index calculation at accept
    hbp_index u_index (
        .i_req        (i_in),
        .i_cfg        (r_cfg),
        .i_hist       (r_hist),
        .o_idx        (idx),
        .o_hist_next  (hist_next),
        .o_hist_shift (hist_shift)
    );

    // table write muxing: clearing pass or training
    always_comb begin
        if (r_clearing) begin
            bim_we    = 1'b1;
            gsh_we    = 1'b1;
            cho_we    = 1'b1;
            bim_waddr = r_clr_idx[MAX_BIMODAL_BITS-1:0];
            gsh_waddr = r_clr_idx[MAX_GSHARE_BITS-1:0];
            cho_waddr = r_clr_idx[MAX_CHOOSER_BITS-1:0];
            bim_wdata = CTR_BIM_INIT;
            gsh_wdata = CTR_GSH_INIT;
            cho_wdata = CTR_CHO_INIT;
        end else begin
            bim_we    = adv && wr.bim_we;
            gsh_we    = adv && wr.gsh_we;
            cho_we    = adv && wr.cho_we;
            bim_waddr = r_s1_idx.bim;
            gsh_waddr = r_s1_idx.gsh;
            cho_waddr = r_s1_idx.cho;
            bim_wdata = wr.bim_data;
            gsh_wdata = wr.gsh_data;
            cho_wdata = wr.cho_data;
        end
    end

    hbp_ram #(.ADDR_W(MAX_BIMODAL_BITS), .DATA_W(CTR_W)) u_bim_ram (
        .i_clk   (i_clk),
        .i_we    (bim_we),
        .i_waddr (bim_waddr),
        .i_wdata (bim_wdata),
        .i_re    (in_acc),
        .i_raddr (idx.bim),
        .o_rdata (bim_rd)
    );

    hbp_ram #(.ADDR_W(MAX_GSHARE_BITS), .DATA_W(CTR_W)) u_gsh_ram (
        .i_clk   (i_clk),
        .i_we    (gsh_we),
        .i_waddr (gsh_waddr),
        .i_wdata (gsh_wdata),
        .i_re    (in_acc),
        .i_raddr (idx.gsh),
        .o_rdata (gsh_rd)
    );

    hbp_ram #(.ADDR_W(MAX_CHOOSER_BITS), .DATA_W(CTR_W)) u_cho_ram (
        .i_clk   (i_clk),
        .i_we    (cho_we),
        .i_waddr (cho_waddr),
        .i_wdata (cho_wdata),
        .i_re    (in_acc),
        .i_raddr (idx.cho),
        .o_rdata (cho_rd)
    );

    // forwarded counters override the stale read
    assign bim_ctr = r_fwd_bim ? r_fwd_bim_val : bim_rd;
    assign gsh_ctr = r_fwd_gsh ? r_fwd_gsh_val : gsh_rd;
    assign cho_ctr = r_fwd_cho ? r_fwd_cho_val : cho_rd;

    hbp_train u_train (
        .i_mode    (r_cfg.mode),
        .i_taken   (r_s1_taken),
        .i_bim_ctr (bim_ctr),
        .i_gsh_ctr (gsh_ctr),
        .i_cho_ctr (cho_ctr),
        .o_pred    (pred),
        .o_wr      (wr)
    );

    // saturating mispredict count and response
    always_comb begin
        mis   = (pred != r_s1_taken);
        n_cnt = (mis && (r_cnt != '1)) ? r_cnt + COUNT_WIDTH'(1) : r_cnt;
        n_out.predicted_taken  = pred;
        n_out.mispredicted     = mis;
        n_out.mispredict_total = 32'(n_cnt);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_HYBRID;
            r_cfg.bim_bits  <= 4'd12;
            r_cfg.gsh_bits  <= 4'd12;
            r_cfg.hist_bits <= 4'd8;
            r_cfg.cho_bits  <= 4'd12;
            r_clearing      <= 1'b1;
            r_clr_idx       <= '0;
            r_hist          <= '0;
            r_cnt           <= '0;
            r_s1_v          <= 1'b0;
            r_out_v         <= 1'b0;
        end else begin
            // config writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MODE:      r_cfg.mode      <= i_cfg_data[1:0];
                    CFG_BIM_BITS:  r_cfg.bim_bits  <= i_cfg_data;
                    CFG_GSH_BITS:  r_cfg.gsh_bits  <= i_cfg_data;
                    CFG_HIST_BITS: r_cfg.hist_bits <= i_cfg_data;
                    CFG_CHO_BITS:  r_cfg.cho_bits  <= i_cfg_data;
                    default: ;
                endcase
            end
            // clearing pass
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + CLR_BITS'(1);
                if (r_clr_idx == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            // history moves at accept, except in bimodal mode
            if (in_acc && hist_shift) begin
                r_hist <= hist_next;
            end
            if (adv) begin
                r_cnt <= n_cnt;
            end
            // stage valids
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (adv) begin
                r_s1_v <= 1'b0;
            end
            if (adv) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_taken    <= i_in.taken;
            r_s1_idx      <= idx;
            r_fwd_bim     <= bim_we && (bim_waddr == idx.bim);
            r_fwd_gsh     <= gsh_we && (gsh_waddr == idx.gsh);
            r_fwd_cho     <= cho_we && (cho_waddr == idx.cho);
            r_fwd_bim_val <= bim_wdata;
            r_fwd_gsh_val <= gsh_wdata;
            r_fwd_cho_val <= cho_wdata;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // checks
    `HBP_ASSERT_IMP(a_clear_stalls, i_clk, i_rst_n, r_clearing, o_in_stall)
    `HBP_ASSERT_IMP(a_clear_empty, i_clk, i_rst_n, r_clearing, !r_s1_v && !r_out_v)
    `HBP_ASSERT_NXT(a_hold_stage, i_clk, i_rst_n, r_s1_v && r_out_v && i_out_stall, r_s1_v)
    `HBP_ASSERT_NXT(a_cnt_mono, i_clk, i_rst_n, adv, r_cnt >= $past(r_cnt))
    `HBP_ASSERT_NXT(a_adv_out, i_clk, i_rst_n, adv, r_out_v)

endmodule
